FILE: hw/rtl/tdp_pkg.sv
// Shared types and constants for the trial-division primality tester.
`default_nettype none
package tdp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // wheel constants
    localparam int SMALL_FIRST = 2;
    localparam int SMALL_LAST  = 7;
    localparam int SMALL_BOUND = 121;
    localparam int WHEEL_START = 11;
    localparam int PAIR_GAP    = 2;
    localparam int WHEEL_REST  = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_SMALL,
        PH_LO,
        PH_HI
    } t_phase;

endpackage
`default_nettype wire

FILE: hw/rtl/trial_division_primality.sv
// Top level: trial-division primality test on a 6k +/- 1 wheel.
//
// Channel   Dir  Signals                               Payload
// s_axis    in   s_axis_tvalid/tready/tdata            candidate (signed)
// m_axis    out  m_axis_tvalid/tready/tdata            is_prime
//
// Each remainder takes a start state, one quotient bit per cycle over VALUE_WIDTH-1 magnitude bits,
// and a done strobe. An item needs up to 5 + 2*k divisions, k pairs up to sqrt(candidate);
// negatives skip the divisions.
// One item is in work at a time; a new one is taken while the last result still waits.
// Reset is synchronous, active low, and clears control only.
`default_nettype none
module trial_division_primality #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [VALUE_WIDTH-1:0] candidate, rest zero
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] is_prime, rest zero
    output logic [7:0]                              m_axis_tdata
);
    import tdp_pkg::*;

    localparam int N = VALUE_WIDTH - 1;

    t_state       r_state, n_state;
    t_phase       r_phase, n_phase;
    logic [N-1:0] r_n;
    logic [N-1:0] r_div, n_div;
    logic         r_neg;
    logic         r_res, n_res;
    logic         r_out_valid, n_out_valid;
    logic         r_out_bit, n_out_bit;

    logic         div_done;
    logic [N-1:0] div_quo;
    logic [N-1:0] div_rem;
    logic         rem_zero;
    logic         take_in;
    logic         out_free;

    assign take_in  = s_axis_tvalid && s_axis_tready;
    assign rem_zero = (div_rem == '0);
    assign out_free = !r_out_valid || m_axis_tready;

    tdp_divider #(.N(N)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_dividend  (r_n),
        .i_divisor   (r_div),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_state = s_axis_tdata[VALUE_WIDTH-1] ? S_DONE : S_START;
                end
            end
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_done) begin
                    case (r_phase)
                        PH_SMALL: begin
                            if (rem_zero || (r_div == N'(SMALL_LAST) &&
                                             r_n < N'(SMALL_BOUND))) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_START;
                            end
                        end
                        PH_LO: begin
                            if (r_div > div_quo || rem_zero) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_START;
                            end
                        end
                        PH_HI: n_state = rem_zero ? S_DONE : S_START;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase     = r_phase;
        n_div       = r_div;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_phase = PH_SMALL;
                n_div   = N'(SMALL_FIRST);
                n_res   = 1'b0;
            end
            S_WAIT: begin
                if (div_done) begin
                    case (r_phase)
                        PH_SMALL: begin
                            if (rem_zero) begin
                                n_res = (r_n == r_div);
                            end else if (r_div == N'(SMALL_LAST)) begin
                                n_res   = (r_n > N'(1));
                                n_div   = N'(WHEEL_START);
                                n_phase = PH_LO;
                            end else if (r_div == N'(SMALL_FIRST)) begin
                                n_div = r_div + N'(1);
                            end else begin
                                n_div = r_div + N'(PAIR_GAP);
                            end
                        end
                        PH_LO: begin
                            n_res   = !rem_zero;
                            n_div   = r_div + N'(PAIR_GAP);
                            n_phase = PH_HI;
                        end
                        PH_HI: begin
                            n_res   = !rem_zero;
                            n_div   = r_div + N'(WHEEL_REST);
                            n_phase = PH_LO;
                        end
                        default: n_res = 1'b0;
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res && !r_neg;
                end
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_phase   <= n_phase;
        r_div     <= n_div;
        r_res     <= n_res;
        r_out_bit <= n_out_bit;
        if (take_in) begin
            r_n   <= s_axis_tdata[N-1:0];
            r_neg <= s_axis_tdata[VALUE_WIDTH-1];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_bit};

endmodule
`default_nettype wire

FILE: hw/rtl/tdp_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module tdp_divider #(
    parameter int N = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [N-1:0] i_divisor,
    output logic              o_done,
    output logic [N-1:0]      o_quotient,
    output logic [N-1:0]      o_remainder
);
    import tdp_pkg::*;

    localparam int CW = $clog2(N + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [N-1:0]  r_quo, n_quo;
    logic [N-1:0]  r_rem, n_rem;
    logic [N-1:0]  r_dsr, n_dsr;
    logic [N:0]    trial;
    logic [N:0]    diff;

    assign trial = {r_rem, r_quo[N-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(N);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!diff[N]) begin
                n_rem = diff[N-1:0];
                n_quo = {r_quo[N-2:0], 1'b1};
            end else begin
                n_rem = trial[N-1:0];
                n_quo = {r_quo[N-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire
